>>> src/answer_word_tokenizer_defines.svh
// Assertion macros shared by the answer word tokenizer RTL.
`ifndef ANSWER_WORD_TOKENIZER_DEFINES_SVH
`define ANSWER_WORD_TOKENIZER_DEFINES_SVH

`ifndef SYNTH

// Checks a condition at every clock edge outside reset.
`define AWT_CHECK(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("awt check failed");

// Checks that a condition implies another in the same cycle.
`define AWT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("awt implication failed");

// Checks that a condition implies another in the next cycle.
`define AWT_IMPLIES_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("awt next-cycle implication failed");

`else

`define AWT_CHECK(label, cond)
`define AWT_IMPLIES(label, ante, cons)
`define AWT_IMPLIES_NEXT(label, ante, cons)

`endif

`endif

>>> src/awt_pkg.sv
// Types and constants shared by the answer word tokenizer modules.
`timescale 1ns / 1ps
`default_nettype none

package awt_pkg;

    // Longest answer string; positions saturate below it and within 8 bits.
    localparam int MAX_STRING_BYTES = 256;
    localparam int IDX_W            = 8;
    localparam int POS_CAP_INT      = ((MAX_STRING_BYTES - 1) < ((1 << IDX_W) - 1)) ?
                                      (MAX_STRING_BYTES - 1) : ((1 << IDX_W) - 1);
    localparam logic [IDX_W-1:0] POS_CAP = IDX_W'(POS_CAP_INT);

    // Separator characters.
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS    = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;

    // Letter ranges and case offset.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Multibyte UTF-8 sequences: right quote E2 80 99 and accent lead C3.
    localparam logic [7:0] QUOTE_LEAD   = 8'hE2;
    localparam logic [7:0] QUOTE_MID    = 8'h80;
    localparam logic [7:0] QUOTE_END    = 8'h99;
    localparam logic [7:0] ACCENT_LEAD  = 8'hC3;
    localparam logic [7:0] ACC_UPPER_LO = 8'h80;
    localparam logic [7:0] ACC_UPPER_HI = 8'h9F;

    // Pending multibyte sequence.
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_Q80  = 2'd1,
        PH_Q99  = 2'd2,
        PH_ACC  = 2'd3
    } t_phase;

    // Error codes reported on the result.
    typedef enum logic [2:0] {
        ERR_NONE            = 3'd0,
        ERR_BAD_CHAR        = 3'd1,
        ERR_BAD_ACCENT      = 3'd2,
        ERR_TRUNC_ACCENT    = 3'd3,
        ERR_BAD_QUOTE       = 3'd4,
        ERR_NESTED_PAREN    = 3'd5,
        ERR_UNMATCHED_CLOSE = 3'd6
    } t_err;

    // Classification of one input byte.
    typedef struct packed {
        logic       is_sep;
        logic       is_quote_lead;
        logic       is_open;
        logic       is_close;
        logic       is_accent_lead;
        logic       is_letter;
        logic [7:0] letter_lc;
        logic       accent_ok;
        logic [7:0] accent_lc;
    } t_class;

    // One result beat.
    typedef struct packed {
        logic             letter_valid;
        logic [7:0]       letter;
        logic             word_begin;
        logic [IDX_W-1:0] word_position;
        logic             word_complete;
        t_err             error_code;
    } t_result;

endpackage

`default_nettype wire

>>> src/answer_word_tokenizer.sv
// Answer word tokenizer top level: input register, step logic, result register.
//
//   Channel  Direction  Handshake                 Beat
//   input    in         i_in_valid / o_in_stall   i_text_byte, i_end_of_string
//   result   out        o_out_valid / i_out_stall o_letter_valid .. o_error_code
//
// One byte is accepted per cycle and one result beat leaves per cycle when the
// result side does not stall. The byte is first registered, then the step logic
// and state update run into the result register.
// Reset (synchronous, active low) clears the state and both stage valids.
// A stall on the result side holds the result register and backs up into the
// input register; the input stalls only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

`include "answer_word_tokenizer_defines.svh"

module answer_word_tokenizer
    import awt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [7:0]       i_text_byte,
    input  wire logic             i_end_of_string,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_letter_valid,
    output logic [7:0]            o_letter,
    output logic                  o_word_begin,
    output logic [IDX_W-1:0]      o_word_position,
    output logic                  o_word_complete,
    output logic [2:0]            o_error_code
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_step;
    logic       w_in_free;
    t_result    w_result;

    // Stage advance: the result register frees when empty or taken.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = r_in_valid && w_out_free;
    assign w_in_free  = !r_in_valid || w_step;
    assign o_in_stall = !w_in_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_end_of_string;
        end
    end

    awt_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    // Result ports.
    assign o_out_valid     = r_out_valid;
    assign o_letter_valid  = r_out.letter_valid;
    assign o_letter        = r_out.letter;
    assign o_word_begin    = r_out.word_begin;
    assign o_word_position = r_out.word_position;
    assign o_word_complete = r_out.word_complete;
    assign o_error_code    = 3'(r_out.error_code);

    // A byte held in the input register is never dropped while it waits.
    `AWT_IMPLIES_NEXT(a_in_held, r_in_valid && !w_step, r_in_valid)

    // A processed byte always lands in the result register.
    `AWT_IMPLIES_NEXT(a_step_lands, w_step, r_out_valid)

endmodule

`default_nettype wire

>>> src/awt_classify.sv
// Byte classifier: separators, letters, quote and accent bytes.
`timescale 1ns / 1ps
`default_nettype none

module awt_classify
    import awt_pkg::*;
(
    input  wire logic [7:0] i_byte,
    output t_class          o_class
);

    logic [7:0] w_ascii_lc;
    logic [7:0] w_accent_lc;

    // Lowercase candidates for a plain ASCII byte and for an accent second byte.
    always_comb begin
        w_ascii_lc = i_byte;
        if (i_byte inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            w_ascii_lc = i_byte + CASE_OFFSET;
        end
        w_accent_lc = i_byte;
        if (i_byte inside {[ACC_UPPER_LO:ACC_UPPER_HI]}) begin
            w_accent_lc = i_byte + CASE_OFFSET;
        end
    end

    // Flag set for the byte.
    always_comb begin
        o_class.is_sep = i_byte inside {[CH_DIGIT0:CH_DIGIT9], CH_SPACE, CH_TAB, CH_APOS,
                                        CH_SLASH, CH_LPAREN, CH_RPAREN, CH_BANG, CH_QMARK,
                                        CH_DOT, CH_COMMA, CH_DASH, CH_COLON, CH_DQUOTE,
                                        CH_LBRACK, CH_RBRACK, QUOTE_LEAD};
        o_class.is_quote_lead  = (i_byte == QUOTE_LEAD);
        o_class.is_open        = (i_byte == CH_LPAREN);
        o_class.is_close       = (i_byte == CH_RPAREN);
        o_class.is_accent_lead = (i_byte == ACCENT_LEAD);
        o_class.is_letter      = w_ascii_lc inside {[CH_LOWER_A:CH_LOWER_Z]};
        o_class.letter_lc      = w_ascii_lc;
        // Grave and acute a, e, i, o, u in lowercase form.
        o_class.accent_ok      = w_accent_lc inside {8'hA0, 8'hA1, 8'hA8, 8'hA9, 8'hAC,
                                                     8'hAD, 8'hB2, 8'hB3, 8'hB9, 8'hBA};
        o_class.accent_lc      = w_accent_lc;
    end

endmodule

`default_nettype wire

>>> src/awt_core.sv
// Tokenizer state and per-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

`include "answer_word_tokenizer_defines.svh"

module awt_core
    import awt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_result         o_result
);

    t_class           w_class;

    logic             r_inside_parens;
    logic             r_word_open;
    t_phase           r_phase;
    logic [IDX_W-1:0] r_byte_index;
    logic [IDX_W-1:0] r_word_start;
    logic             r_err_latched;

    logic             n_inside_parens;
    logic             n_word_open;
    t_phase           n_phase;
    logic [IDX_W-1:0] n_byte_index;
    logic [IDX_W-1:0] n_word_start;
    logic             n_err_latched;

    logic             w_lv;
    logic [7:0]       w_letter;
    logic             w_wb;
    logic             w_wc;
    t_err             w_err;

    awt_classify u_classify (
        .i_byte  (i_byte),
        .o_class (w_class)
    );

    // Step of the tokenizer for the byte held at the input register.
    always_comb begin
        n_inside_parens = r_inside_parens;
        n_word_open     = r_word_open;
        n_phase         = r_phase;
        n_word_start    = r_word_start;
        n_err_latched   = r_err_latched;
        w_lv            = 1'b0;
        w_letter        = '0;
        w_wb            = 1'b0;
        w_wc            = 1'b0;
        w_err           = ERR_NONE;

        if (!r_err_latched) begin
            case (r_phase)
                PH_Q80: begin
                    if (i_byte != QUOTE_MID || i_last) begin
                        w_err = ERR_BAD_QUOTE;
                    end else begin
                        n_phase = PH_Q99;
                    end
                end
                PH_Q99: begin
                    if (i_byte != QUOTE_END) begin
                        w_err = ERR_BAD_QUOTE;
                    end else begin
                        n_phase = PH_NONE;
                    end
                end
                PH_ACC: begin
                    if (w_class.accent_ok) begin
                        w_lv     = 1'b1;
                        w_letter = w_class.accent_lc;
                        w_wc     = i_last;
                        n_phase  = PH_NONE;
                    end else begin
                        w_err = ERR_BAD_ACCENT;
                    end
                end
                default: begin
                    // No multibyte sequence pending.
                    if (w_class.is_sep) begin
                        w_wc        = r_word_open;
                        n_word_open = 1'b0;
                        if (w_class.is_quote_lead) begin
                            if (i_last) begin
                                w_err = ERR_BAD_QUOTE;
                            end else begin
                                n_phase = PH_Q80;
                            end
                        end else if (w_class.is_open) begin
                            if (r_inside_parens) begin
                                w_err = ERR_NESTED_PAREN;
                            end else begin
                                n_inside_parens = 1'b1;
                            end
                        end else if (w_class.is_close) begin
                            if (!r_inside_parens) begin
                                w_err = ERR_UNMATCHED_CLOSE;
                            end else begin
                                n_inside_parens = 1'b0;
                            end
                        end
                    end else if (!r_inside_parens) begin
                        if (!r_word_open) begin
                            n_word_open  = 1'b1;
                            n_word_start = r_byte_index;
                            w_wb         = 1'b1;
                        end
                        if (w_class.is_accent_lead) begin
                            if (i_last) begin
                                w_err = ERR_TRUNC_ACCENT;
                            end else begin
                                w_lv     = 1'b1;
                                w_letter = i_byte;
                                n_phase  = PH_ACC;
                            end
                        end else if (w_class.is_letter) begin
                            w_lv     = 1'b1;
                            w_letter = w_class.letter_lc;
                            w_wc     = i_last;
                        end else begin
                            w_err = ERR_BAD_CHAR;
                        end
                    end
                end
            endcase

            // An error blanks the beat and latches until the string ends.
            if (w_err != ERR_NONE) begin
                w_lv          = 1'b0;
                w_letter      = '0;
                w_wb          = 1'b0;
                w_wc          = 1'b0;
                n_err_latched = 1'b1;
            end
        end

        // Saturating byte position.
        n_byte_index = r_byte_index;
        if (r_byte_index < POS_CAP) begin
            n_byte_index = r_byte_index + 1'b1;
        end

        // The last byte returns everything to the reset state.
        if (i_last) begin
            n_inside_parens = 1'b0;
            n_word_open     = 1'b0;
            n_phase         = PH_NONE;
            n_byte_index    = '0;
            n_word_start    = '0;
            n_err_latched   = 1'b0;
        end
    end

    // Result fields for this byte.
    always_comb begin
        o_result.letter_valid  = w_lv;
        o_result.letter        = w_letter;
        o_result.word_begin    = w_wb;
        o_result.word_position = (w_lv || w_wc) ?
                                 (w_wb ? r_byte_index : r_word_start) : '0;
        o_result.word_complete = w_wc;
        o_result.error_code    = w_err;
    end

    // State registers advance once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside_parens <= 1'b0;
            r_word_open     <= 1'b0;
            r_phase         <= PH_NONE;
            r_byte_index    <= '0;
            r_word_start    <= '0;
            r_err_latched   <= 1'b0;
        end else if (i_step) begin
            r_inside_parens <= n_inside_parens;
            r_word_open     <= n_word_open;
            r_phase         <= n_phase;
            r_byte_index    <= n_byte_index;
            r_word_start    <= n_word_start;
            r_err_latched   <= n_err_latched;
        end
    end

    // An error beat carries no letter and no word marks.
    `AWT_IMPLIES(a_err_beat_blank, i_step && o_result.error_code != ERR_NONE, !o_result.letter_valid && !o_result.word_begin && !o_result.word_complete)

    // Once an error is latched, bytes are swallowed silently.
    `AWT_IMPLIES(a_latched_silent, i_step && r_err_latched, o_result.error_code == ERR_NONE && !o_result.letter_valid && !o_result.word_complete)

    // A word only begins on an emitted byte.
    `AWT_IMPLIES(a_begin_emits, i_step && o_result.word_begin, o_result.letter_valid)

    // The last byte leaves the block in its reset state.
    `AWT_IMPLIES_NEXT(a_last_clears, i_step && i_last, r_phase == PH_NONE && !r_err_latched && !r_inside_parens && !r_word_open && r_byte_index == '0)

endmodule

`default_nettype wire
